// ===== sv/sal_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and controller/datapath interface types for the lru cache lookup
// no dependencies
package sal_pkg;

	localparam int ADDR_W          = 32;
	localparam int TAG_W           = 25;
	localparam int WAY_OUT_W       = 2;
	localparam int CNT_W           = 32;

	localparam int DEF_WAYS        = 4;
	localparam int DEF_SETS        = 4;
	localparam int DEF_OFFSET_BITS = 5;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_addr;
		logic mem_read;
		logic eval;
		logic mem_write;
		logic clr_write;
		logic out_load;
	} sal_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic out_free;
	} sal_status_t;

endpackage

// ===== sv/set_assoc_lru_cache_lookup.sv =====
`timescale 1ns / 1ps
// Set-associative read cache lookup with true lru replacement. Each accepted word is a byte
// address; block = address >> OFFSET_BITS, set = block mod SETS, tag = low 25 bits of
// block / SETS. A hit makes that way most recently used; a miss fills the lowest invalid way
// or else evicts the least recently used one and reports its tag. Access and miss counters
// saturate at all ones. After reset the block sweeps the set memory, one set a cycle, over
// all SETS sets with in_ready low. A word then goes from acceptance to the next acceptance
// through accept, split, memory read, compare and pick, and write-back when SETS is a power
// of two, the single-port set memory read then write being the limit; write-back waits while
// the output register still holds a result that out_ready has not taken. For other set
// counts the split by reciprocal multiplication adds a quotient step then a remainder step.
// The result sits in an output register, so the next word is taken while a result waits for out_ready.
// depends on sal_pkg, sal_ctrl and sal_dpath
module set_assoc_lru_cache_lookup import sal_pkg::*; #(
	parameter int WAYS        = DEF_WAYS,
	parameter int SETS        = DEF_SETS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ADDR_W-1:0]    address,
	// result side
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [WAY_OUT_W-1:0] way,
	output logic                 evicted_valid,
	output logic [TAG_W-1:0]     evicted_tag,
	output logic [CNT_W-1:0]     access_count,
	output logic [CNT_W-1:0]     miss_count
);

	sal_cmd_t    cmd;
	sal_status_t status;

	// sequencing: clear sweep, split, read, evaluate, write-back
	sal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// set memory, compare and lru update, counters, output register
	sal_dpath #(
		.WAYS        (WAYS),
		.SETS        (SETS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.address       (address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.way           (way),
		.evicted_valid (evicted_valid),
		.evicted_tag   (evicted_tag),
		.access_count  (access_count),
		.miss_count    (miss_count)
	);

endmodule

// ===== sv/sal_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for the lru cache lookup
// depends on sal_pkg
module sal_ctrl import sal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sal_status_t status,
	output sal_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EVAL,
		ST_WRITE,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			in_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_last) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_DIV;
						in_ready_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE, ST_HOLD: begin
					if (status.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				default: begin
					state_q    <= ST_CLEAR;
					in_ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

	always_comb begin
		cmd           = '0;
		cmd.load_addr = (state_q == ST_IDLE) && in_valid && in_ready_q;
		cmd.mem_read  = (state_q == ST_READ);
		cmd.eval      = (state_q == ST_EVAL);
		cmd.mem_write = (state_q == ST_WRITE);
		cmd.clr_write = (state_q == ST_CLEAR);
		cmd.out_load  = ((state_q == ST_WRITE) || (state_q == ST_HOLD)) && status.out_free;
	end

endmodule

// ===== sv/sal_dpath.sv =====
`timescale 1ns / 1ps
// address split, set memory, hit and victim logic, counters and output register
// depends on sal_pkg
module sal_dpath import sal_pkg::*; #(
	parameter int WAYS        = DEF_WAYS,
	parameter int SETS        = DEF_SETS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sal_cmd_t             cmd,
	output sal_status_t          status,
	input  logic [ADDR_W-1:0]    address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [WAY_OUT_W-1:0] way,
	output logic                 evicted_valid,
	output logic [TAG_W-1:0]     evicted_tag,
	output logic [CNT_W-1:0]     access_count,
	output logic [CNT_W-1:0]     miss_count
);

	localparam int BLK_W   = ADDR_W - OFFSET_BITS;
	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_W   = 1 + TAG_W + AGE_W;
	localparam int ROW_W   = WAYS * WAY_W;
	localparam bit SETS_P2 = (SETS & (SETS - 1)) == 0;

	logic [SET_W-1:0] set_idx;
	logic [BLK_W-1:0] tag_full;
	logic             div_done;

	// address split: set = block mod SETS, tag = block / SETS
	if (SETS == 1) begin : g_one_set
		logic [BLK_W-1:0] blk_q;
		always_ff @(posedge clk) begin
			if (cmd.load_addr) begin
				blk_q <= address[ADDR_W-1:OFFSET_BITS];
			end
		end
		assign set_idx  = '0;
		assign tag_full = blk_q;
		assign div_done = 1'b1;
	end else if (SETS_P2) begin : g_pow2
		logic [BLK_W-1:0] blk_q;
		always_ff @(posedge clk) begin
			if (cmd.load_addr) begin
				blk_q <= address[ADDR_W-1:OFFSET_BITS];
			end
		end
		assign set_idx  = blk_q[SET_W-1:0];
		assign tag_full = blk_q >> SET_W;
		assign div_done = 1'b1;
	end else begin : g_recip
		// quotient by a rounded-up reciprocal, exact over the whole block range,
		// then the remainder from the low bits of block - quotient * SETS
		localparam int              REC_SH = BLK_W + SET_W;
		localparam int              PROD_W = 2 * BLK_W + 1;
		localparam longint unsigned REC_ML = ((64'd1 << REC_SH) + 64'(SETS) - 64'd1)
			/ 64'(SETS);
		localparam logic [BLK_W:0]  REC_M  = (BLK_W + 1)'(REC_ML);

		logic [BLK_W-1:0]  blk_q;
		logic [BLK_W-1:0]  quo_q;
		logic [SET_W-1:0]  rem_q;
		logic [1:0]        step_q;
		logic [PROD_W-1:0] prod;
		logic [SET_W-1:0]  qd_lo;

		assign prod  = PROD_W'(blk_q) * PROD_W'(REC_M);
		assign qd_lo = SET_W'(quo_q[SET_W-1:0] * SET_W'(SETS));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_q <= '0;
			end else if (cmd.load_addr) begin
				step_q <= 2'd2;
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.load_addr) begin
				blk_q <= address[ADDR_W-1:OFFSET_BITS];
			end
			if (step_q == 2'd2) begin
				quo_q <= BLK_W'(prod >> REC_SH);
			end
			if (step_q == 2'd1) begin
				rem_q <= blk_q[SET_W-1:0] - qd_lo;
			end
		end

		assign set_idx  = rem_q;
		assign tag_full = quo_q;
		assign div_done = (step_q == '0);
	end

	logic [TAG_W-1:0] tag_cur;
	assign tag_cur = tag_full[TAG_W-1:0];

	// one row per set: every way holds valid, tag and age
	logic [ROW_W-1:0] row_mem [SETS];
	logic [ROW_W-1:0] rdata_q;
	logic [ROW_W-1:0] new_row_q;
	logic [SET_W-1:0] clr_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_write) begin
			row_mem[clr_idx_q] <= '0;
		end else if (cmd.mem_write) begin
			row_mem[set_idx] <= new_row_q;
		end
		if (cmd.mem_read) begin
			rdata_q <= row_mem[set_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_write) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// lookup and replacement
	logic              v_w [WAYS];
	logic [TAG_W-1:0]  t_w [WAYS];
	logic [AGE_W-1:0]  a_w [WAYS];
	logic              hit_any;
	logic              free_any;
	logic [WIDX_W-1:0] hit_w;
	logic [WIDX_W-1:0] free_w;
	logic [WIDX_W-1:0] lru_w;
	logic [WIDX_W-1:0] sel_w;
	logic [AGE_W:0]    old_age;
	logic [ROW_W-1:0]  new_row;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_w    = '0;
		free_w   = '0;
		lru_w    = '0;
		// walk downwards so the lowest way wins
		for (int i = WAYS - 1; i >= 0; i--) begin
			v_w[i] = rdata_q[i * WAY_W + AGE_W + TAG_W];
			t_w[i] = rdata_q[i * WAY_W + AGE_W +: TAG_W];
			a_w[i] = rdata_q[i * WAY_W +: AGE_W];
			if (v_w[i] && (t_w[i] == tag_cur)) begin
				hit_any = 1'b1;
				hit_w   = WIDX_W'(i);
			end
			if (!v_w[i]) begin
				free_any = 1'b1;
				free_w   = WIDX_W'(i);
			end
			// valid ages form a permutation, so the oldest holds WAYS-1
			if (a_w[i] == AGE_W'(WAYS - 1)) begin
				lru_w = WIDX_W'(i);
			end
		end
		sel_w   = hit_any ? hit_w : (free_any ? free_w : lru_w);
		old_age = v_w[sel_w] ? {1'b0, a_w[sel_w]} : (AGE_W + 1)'(WAYS);
		for (int i = 0; i < WAYS; i++) begin
			if (WIDX_W'(i) == sel_w) begin
				new_row[i * WAY_W +: WAY_W] = {1'b1, tag_cur, AGE_W'(0)};
			end else if (v_w[i] && ({1'b0, a_w[i]} < old_age)) begin
				new_row[i * WAY_W +: WAY_W] = {v_w[i], t_w[i], AGE_W'(a_w[i] + 1'b1)};
			end else begin
				new_row[i * WAY_W +: WAY_W] = {v_w[i], t_w[i], a_w[i]};
			end
		end
	end

	logic              res_hit_q;
	logic [WIDX_W-1:0] res_way_q;
	logic              res_ev_valid_q;
	logic [TAG_W-1:0]  res_ev_tag_q;
	logic [CNT_W-1:0]  acc_q;
	logic [CNT_W-1:0]  miss_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			new_row_q      <= new_row;
			res_hit_q      <= hit_any;
			res_way_q      <= sel_w;
			res_ev_valid_q <= !hit_any && !free_any;
			res_ev_tag_q   <= (!hit_any && !free_any) ? t_w[sel_w] : '0;
		end
	end

	// saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			miss_q <= '0;
		end else if (cmd.eval) begin
			if (acc_q != '1) begin
				acc_q <= acc_q + 1'b1;
			end
			if (!hit_any && (miss_q != '1)) begin
				miss_q <= miss_q + 1'b1;
			end
		end
	end

	// output register
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [WAY_OUT_W-1:0] out_way_q;
	logic                 out_ev_valid_q;
	logic [TAG_W-1:0]     out_ev_tag_q;
	logic [CNT_W-1:0]     out_acc_q;
	logic [CNT_W-1:0]     out_miss_q;
	logic [WIDX_W+WAY_OUT_W-1:0] way_ext;

	assign way_ext = {{WAY_OUT_W{1'b0}}, res_way_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hit_q      <= res_hit_q;
			out_way_q      <= way_ext[WAY_OUT_W-1:0];
			out_ev_valid_q <= res_ev_valid_q;
			out_ev_tag_q   <= res_ev_tag_q;
			out_acc_q      <= acc_q;
			out_miss_q     <= miss_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign way           = out_way_q;
	assign evicted_valid = out_ev_valid_q;
	assign evicted_tag   = out_ev_tag_q;
	assign access_count  = out_acc_q;
	assign miss_count    = out_miss_q;

	always_comb begin
		status          = '0;
		status.clr_last = (clr_idx_q == SET_W'(SETS - 1));
		status.div_done = div_done;
		status.out_free = !out_valid_q || out_ready;
	end

endmodule

// ===== sv/sal_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the lru cache lookup, bound to the top level
// depends on sal_pkg and set_assoc_lru_cache_lookup
module sal_checker import sal_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [ADDR_W-1:0]    address,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic [WAY_OUT_W-1:0] way,
	input logic                 evicted_valid,
	input logic [TAG_W-1:0]     evicted_tag,
	input logic [CNT_W-1:0]     access_count,
	input logic [CNT_W-1:0]     miss_count
);

	// a waiting word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(access_count) && $stable(way)
		&& $stable(address) == $stable(address))
		else $error("result word changed while stalled");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("hit reported an eviction");

	// no eviction means no evicted tag
	a_evict_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_tag == '0)
		else $error("evicted tag without eviction");

	// misses are a subset of accesses
	a_miss_le_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> miss_count <= access_count)
		else $error("miss count above access count");

	// a result never appears the cycle after a request is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too early after request");

endmodule

bind set_assoc_lru_cache_lookup sal_checker u_sal_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.address       (address),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.way           (way),
	.evicted_valid (evicted_valid),
	.evicted_tag   (evicted_tag),
	.access_count  (access_count),
	.miss_count    (miss_count)
);
